// File: rtl/fbpa_pkg.sv
// shared constants, codes and types of the fixed block pool allocator
package fbpa_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int ADDR_W     = 32;
    localparam int BSIZE_W    = 17;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = $clog2(ADDR_W);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_BAD_FREE = 2'd2;

    // operations of the shared multiply/divide unit
    typedef enum logic {
        IU_MUL,
        IU_DIV
    } t_iu_op;

    typedef struct packed {
        logic   start;
        t_iu_op op;
    } t_iu_req;

    // control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_LINK,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

endpackage

// File: rtl/fbpa_iter_unit.sv
// iterative shift-add multiplier and restoring divider around one shared adder
module fbpa_iter_unit
    import fbpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_iu_req             i_req,
    input  logic [ADDR_W-1:0]   i_a,
    input  logic [BSIZE_W-1:0]  i_b,
    input  logic [IDX_W-1:0]    i_m,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_result
);

    logic                r_busy;
    logic                r_done;
    t_iu_op              r_op;
    logic [STEP_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]   r_acc;
    logic [BSIZE_W-1:0]  r_rem;
    logic [ADDR_W-1:0]   r_mc;
    logic [IDX_W-1:0]    r_mp;
    logic [BSIZE_W-1:0]  r_div;

    logic [BSIZE_W:0]    rem_sh;
    logic [ADDR_W:0]     opa;
    logic [ADDR_W:0]     opb;
    logic                cin;
    logic [ADDR_W+1:0]   sum;
    logic                carry;

    // operand select for the shared adder
    always_comb begin
        rem_sh = {r_rem, r_acc[ADDR_W-1]};
        if (r_op == IU_MUL) begin
            opa = {1'b0, r_acc};
            opb = r_mp[0] ? {1'b0, r_mc} : '0;
            cin = 1'b0;
        end else begin
            opa = {{(ADDR_W-BSIZE_W){1'b0}}, rem_sh};
            opb = ~{{(ADDR_W+1-BSIZE_W){1'b0}}, r_div};
            cin = 1'b1;
        end
        sum   = {1'b0, opa} + {1'b0, opb} + {{(ADDR_W+1){1'b0}}, cin};
        carry = sum[ADDR_W+1];
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= IU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == IU_MUL) ? STEP_W'(IDX_W - 1) : STEP_W'(ADDR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: one multiplier bit or one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_a;
            r_rem <= '0;
            r_mc  <= {{(ADDR_W-BSIZE_W){1'b0}}, i_b};
            r_div <= i_b;
            r_mp  <= i_m;
        end else if (r_busy) begin
            if (r_op == IU_MUL) begin
                r_acc <= sum[ADDR_W-1:0];
                r_mc  <= {r_mc[ADDR_W-2:0], 1'b0};
                r_mp  <= {1'b0, r_mp[IDX_W-1:1]};
            end else begin
                r_rem <= carry ? sum[BSIZE_W-1:0] : rem_sh[BSIZE_W-1:0];
                r_acc <= {r_acc[ADDR_W-2:0], carry};
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// File: rtl/fixed_block_pool_allocator.sv
// top level: pool state, link table, request sequencer and result register
//
// Fixed-size block pool allocator with a lazily built free list.
// Requests arrive on i_valid/o_ready with i_command (allocate or free) and
// i_free_address; each one yields exactly one result on o_valid/i_ready with
// status, block address, block index and the free count.
// One request is worked at a time; o_ready is high only while idle.
// An allocate reads the link table (S_ALLOC_RD, S_ALLOC_LINK), then runs an
// 8-step shift-add multiply for base + index * size; when it hands out the
// last free block it skips the link read. A free runs a 32-step restoring
// division of the offset by the block size. A request rejected for an empty
// pool, a zero block size or a free while every block is free goes straight
// to the result. Both long paths share the one adder of fbpa_iter_unit.
// o_ready rises with o_valid, once the result is in the output register.
// A finished result waits in the output register while i_ready is low; the
// sequencer holds in its final state until that register is free.
// Reset clears the sequencer, loads the default configuration (base 0,
// block size 64, 256 blocks) and restarts the pool; a configuration write
// through i_cfg_wr_en restarts the pool the same way. The link table is not
// cleared: entries are written lazily before they are read.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_command,
    input  logic [ADDR_W-1:0]     i_free_address,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic [ADDR_W-1:0]     o_block_address,
    output logic [IDX_W-1:0]      o_block_index,
    output logic [CNT_W-1:0]      o_free_blocks
);

    // configuration
    logic [ADDR_W-1:0]   r_base;
    logic [BSIZE_W-1:0]  r_bsize;
    logic [CNT_W-1:0]    r_bcount;
    logic [CNT_W-1:0]    cfg_count;
    logic                cfg_hit;
    logic [CNT_W-1:0]    pool_n;
    logic [CNT_W-1:0]    cfg_pool_n;

    // pool state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic                r_hv, n_hv;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [CNT_W-1:0]    r_init, n_init;

    // working registers of the current request
    logic [IDX_W-1:0]    r_got, n_got;
    logic [ADDR_W-1:0]   r_offset, n_offset;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;

    // result register
    logic                r_out_valid, n_out_valid;
    logic                out_load;
    t_status             r_o_status;
    logic [ADDR_W-1:0]   r_o_addr;
    logic [IDX_W-1:0]    r_o_idx;
    logic [CNT_W-1:0]    r_o_free;

    // link table
    logic [CNT_W-1:0]    r_link [MAX_BLOCKS];
    logic [CNT_W-1:0]    r_link_rd;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [CNT_W-1:0]    mem_wdata;

    // shared unit
    t_iu_req             iu_req;
    logic [ADDR_W-1:0]   iu_a;
    logic                iu_done;
    logic [ADDR_W-1:0]   iu_result;

    logic                avail;

    fbpa_iter_unit u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (iu_req),
        .i_a      (iu_a),
        .i_b      (r_bsize),
        .i_m      (r_got),
        .o_done   (iu_done),
        .o_result (iu_result)
    );

    // block count clamped to the table depth, now and after a config write
    assign pool_n    = (r_bcount > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_bcount;
    assign cfg_hit   = i_cfg_wr_en && (i_cfg_index == CFG_BASE_ADDRESS ||
                       i_cfg_index == CFG_BLOCK_SIZE || i_cfg_index == CFG_BLOCK_COUNT);
    assign cfg_count = (i_cfg_index == CFG_BLOCK_COUNT) ? i_cfg_wdata[CNT_W-1:0] : r_bcount;
    assign cfg_pool_n = (cfg_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_bsize  <= BSIZE_W'(64);
            r_bcount <= CNT_W'(MAX_BLOCKS);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BASE_ADDRESS: r_base   <= i_cfg_wdata;
                CFG_BLOCK_SIZE:   r_bsize  <= i_cfg_wdata[BSIZE_W-1:0];
                CFG_BLOCK_COUNT:  r_bcount <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign avail = (r_free != '0) && r_hv && ({1'b0, r_head} < pool_n);

    // sequencer: next state and pool updates
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_hv        = r_hv;
        n_free      = r_free;
        n_init      = r_init;
        n_got       = r_got;
        n_offset    = r_offset;
        n_status    = r_status;
        n_res_addr  = r_res_addr;
        n_res_idx   = r_res_idx;
        n_out_valid = r_out_valid && !i_ready;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_init[IDX_W-1:0];
        mem_wdata   = r_init + 1'b1;
        iu_req      = '{start: 1'b0, op: IU_MUL};
        iu_a        = r_base;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_ALLOC) begin
                        // extend the lazy list by one entry
                        if (r_init < pool_n) begin
                            mem_we = 1'b1;
                            n_init = r_init + 1'b1;
                        end
                        if (avail) begin
                            n_got     = r_head;
                            n_free    = r_free - 1'b1;
                            n_status  = ST_OK;
                            n_res_idx = r_head;
                            if (r_free != CNT_W'(1)) begin
                                n_state = S_ALLOC_RD;
                            end else begin
                                n_hv    = 1'b0;
                                n_state = S_MUL_GO;
                            end
                        end else begin
                            n_status   = ST_EMPTY;
                            n_res_addr = '0;
                            n_res_idx  = '0;
                            n_state    = S_OUT;
                        end
                    end else begin
                        n_res_addr = '0;
                        if (r_bsize == '0 || r_free >= pool_n) begin
                            n_status  = ST_BAD_FREE;
                            n_res_idx = '0;
                            n_state   = S_OUT;
                        end else begin
                            n_offset = i_free_address - r_base;
                            n_state  = S_DIV_GO;
                        end
                    end
                end
            end
            S_ALLOC_RD: begin
                n_state = S_ALLOC_LINK;
            end
            S_ALLOC_LINK: begin
                // pop the head; a link past the pool marks the list empty
                if (r_link_rd < pool_n) begin
                    n_head = r_link_rd[IDX_W-1:0];
                end else begin
                    n_hv = 1'b0;
                end
                n_state = S_MUL_GO;
            end
            S_MUL_GO: begin
                iu_req  = '{start: 1'b1, op: IU_MUL};
                iu_a    = r_base;
                n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (iu_done) begin
                    n_res_addr = iu_result;
                    n_state    = S_OUT;
                end
            end
            S_DIV_GO: begin
                iu_req  = '{start: 1'b1, op: IU_DIV};
                iu_a    = r_offset;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (iu_done) begin
                    if (iu_result >= ADDR_W'(pool_n)) begin
                        n_status  = ST_BAD_FREE;
                        n_res_idx = '0;
                    end else begin
                        // push the freed block onto the list
                        mem_we    = 1'b1;
                        mem_waddr = iu_result[IDX_W-1:0];
                        mem_wdata = r_hv ? {1'b0, r_head} : pool_n;
                        n_head    = iu_result[IDX_W-1:0];
                        n_hv      = 1'b1;
                        n_free    = r_free + 1'b1;
                        n_status  = ST_OK;
                        n_res_idx = iu_result[IDX_W-1:0];
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a configuration write restarts the pool
        if (cfg_hit) begin
            n_head = '0;
            n_hv   = (cfg_pool_n != '0);
            n_free = cfg_pool_n;
            n_init = '0;
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_hv        <= 1'b1;
            r_free      <= CNT_W'(MAX_BLOCKS);
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_hv        <= n_hv;
            r_free      <= n_free;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_got      <= n_got;
        r_offset   <= n_offset;
        r_status   <= n_status;
        r_res_addr <= n_res_addr;
        r_res_idx  <= n_res_idx;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_addr   <= r_res_addr;
            r_o_idx    <= r_res_idx;
            r_o_free   <= r_free;
        end
    end

    // link table: one write port, registered read of the popped block
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= mem_wdata;
        end
        r_link_rd <= r_link[r_got];
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_block_address = r_o_addr;
    assign o_block_index   = r_o_idx;
    assign o_free_blocks   = r_o_free;

endmodule
